FILE: hdl/bse_pkg.sv
// Package for the bubble sort engine: set size, derived widths and the element type.
// Has no dependencies. It is used by bubble_sort_engine_core.
`default_nettype none

package bse_pkg;

	// Largest number of elements kept in one set.
	localparam int SIZE = 16;

	// Width of an index into the element store.
	localparam int IDX_W = (SIZE > 1) ? $clog2(SIZE) : 1;

	// Width of the fill count, which must be able to hold SIZE itself.
	localparam int CNT_W = $clog2(SIZE + 1);

	typedef logic signed [15:0] value_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

FILE: hdl/bubble_sort_engine_core.sv
// Top level of the bubble sort engine: element store, pass sequencer and output register.
// Depends on bse_pkg for the set size, the index widths and the element type.
//
// Usage. The input channel (in_valid, in_stall, value, is_last) takes one element per item.
// Elements are kept in arrival order until an item with is_last set arrives; up to SIZE are
// kept and any further elements of the same set are dropped, although an is_last flag on a
// dropped item still closes the set. While a set loads, in_stall is low and an item is taken
// in every cycle. Once the set is closed, in_stall stays high until the last sorted item has
// been handed to the output register.
// The sort is a bubble sort built around one signed comparator and a single-port-read,
// single-port-write element store. A pass streams the store once: a carry register holds the
// largest value seen so far, and each cycle the smaller of the carry and the element just
// read is written one place to the left. Sorting stops after the first pass without a swap
// or after the pass over the first two elements.
// The output channel (out_valid, out_stall, sorted_value, end_of_set) then presents the set
// in ascending order, one item at a time (a store read in EMIT_FETCH, then a register load
// in EMIT_LOAD), with end_of_set high on the final item. When the receiver stalls, the output
// register holds its item unchanged and the sequencer waits. The output register may still
// hold the final item while the next set is already loading.
// An asynchronous reset (arst_n low) empties the set and clears out_valid; the store content
// is left as it was, since only entries written in the current set are ever read.
`default_nettype none

module bubble_sort_engine_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_stall,
	input  bse_pkg::value_t value,
	input  wire             is_last,
	output logic            out_valid,
	input  wire             out_stall,
	output bse_pkg::value_t sorted_value,
	output logic            end_of_set
);

	import bse_pkg::*;

	// Sequencer states. SORT_FIRST takes the first element of a pass into the carry,
	// SORT_CMP compares the carry with the next element, SORT_TAIL writes the carry at
	// the end of the pass. EMIT_FETCH and EMIT_LOAD move one element to the output.
	typedef enum logic [2:0] {
		LOAD,
		SORT_FIRST,
		SORT_CMP,
		SORT_TAIL,
		EMIT_FETCH,
		EMIT_LOAD
	} state_t;

	state_t state_q;
	cnt_t   count_q;
	idx_t   last_idx_q;
	idx_t   limit_q;
	idx_t   pos_q;
	idx_t   out_idx_q;
	value_t carry_q;
	logic   swapped_q;
	value_t rd_data_q;
	logic   out_valid_q;
	value_t sorted_value_q;
	logic   end_of_set_q;

	value_t store_q [SIZE];

	logic   in_accept;
	logic   has_room;
	cnt_t   set_count;
	idx_t   rd_addr;
	logic   wr_en;
	idx_t   wr_addr;
	value_t wr_data;
	logic   carry_gt;
	logic   out_free;

	assign in_stall     = (state_q != LOAD);
	assign in_accept    = in_valid && !in_stall;
	assign has_room     = (count_q < CNT_W'(SIZE));
	assign set_count    = has_room ? count_q + CNT_W'(1) : count_q;
	assign carry_gt     = (carry_q > rd_data_q);
	assign out_free     = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign end_of_set   = end_of_set_q;

	// Read address of the store for the next cycle.
	always_comb begin
		case (state_q)
			SORT_FIRST: rd_addr = idx_t'(1);
			SORT_CMP:   rd_addr = pos_q + idx_t'(1);
			EMIT_FETCH: rd_addr = out_idx_q;
			EMIT_LOAD:  rd_addr = out_idx_q;
			default:    rd_addr = '0;
		endcase
	end

	// Write port: loading, the left shift of the smaller value, and the carry at a pass end.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = value;
		case (state_q)
			LOAD: begin
				wr_en = in_accept && has_room;
			end
			SORT_CMP: begin
				wr_en   = 1'b1;
				wr_addr = pos_q - idx_t'(1);
				wr_data = carry_gt ? rd_data_q : carry_q;
			end
			SORT_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = limit_q;
				wr_data = carry_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_data_q <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills from EMIT_LOAD and empties once its item is taken.
			if (state_q == EMIT_LOAD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				LOAD: begin
					if (in_accept) begin
						count_q <= set_count;
						if (is_last) begin
							last_idx_q <= idx_t'(set_count - CNT_W'(1));
							limit_q    <= idx_t'(set_count - CNT_W'(1));
							swapped_q  <= 1'b0;
							out_idx_q  <= '0;
							// A single element needs no pass.
							if (set_count == CNT_W'(1)) begin
								state_q <= EMIT_FETCH;
							end else begin
								state_q <= SORT_FIRST;
							end
						end
					end
				end
				SORT_FIRST: begin
					carry_q <= rd_data_q;
					pos_q   <= idx_t'(1);
					state_q <= SORT_CMP;
				end
				SORT_CMP: begin
					if (carry_gt) begin
						swapped_q <= 1'b1;
					end else begin
						carry_q <= rd_data_q;
					end
					if (pos_q == limit_q) begin
						state_q <= SORT_TAIL;
					end else begin
						pos_q <= pos_q + idx_t'(1);
					end
				end
				SORT_TAIL: begin
					swapped_q <= 1'b0;
					if (!swapped_q || limit_q == idx_t'(1)) begin
						state_q <= EMIT_FETCH;
					end else begin
						limit_q <= limit_q - idx_t'(1);
						state_q <= SORT_FIRST;
					end
				end
				EMIT_FETCH: begin
					state_q <= EMIT_LOAD;
				end
				EMIT_LOAD: begin
					if (out_free) begin
						sorted_value_q <= rd_data_q;
						end_of_set_q   <= (out_idx_q == last_idx_q);
						if (out_idx_q == last_idx_q) begin
							count_q <= '0;
							state_q <= LOAD;
						end else begin
							out_idx_q <= out_idx_q + idx_t'(1);
							state_q   <= EMIT_FETCH;
						end
					end
				end
				default: begin
					state_q <= LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: verif/bse_sorted_board_pkg.sv
// Scoreboard for the bubble sort engine testbench: predicts the sorted output of every set.
// Depends on bse_pkg for the set size and the element type.
package bse_sorted_board_pkg;

	import bse_pkg::*;

	class sorted_order_board;

		value_t held[SIZE];
		int     kept;
		value_t sorted_q[$];
		bit     end_q[$];
		int     errors;
		int     sets_closed;
		int     results_checked;

		function new();
			kept = 0;
			errors = 0;
			sets_closed = 0;
			results_checked = 0;
		endfunction

		// Ascending bubble sort on the held values; a pass without a swap ends it.
		function void sort_held();
			value_t tmp;
			bit     swapped;
			for (int p = 0; p + 1 < kept; p++) begin
				swapped = 1'b0;
				for (int i = 0; i + 1 < kept - p; i++) begin
					if (held[i] > held[i + 1]) begin
						tmp = held[i];
						held[i] = held[i + 1];
						held[i + 1] = tmp;
						swapped = 1'b1;
					end
				end
				if (!swapped)
					break;
			end
		endfunction

		function void note_element(value_t v, bit last);
			if (kept < SIZE) begin
				held[kept] = v;
				kept++;
			end
			if (last) begin
				sort_held();
				for (int k = 0; k < kept; k++) begin
					sorted_q.push_back(held[k]);
					end_q.push_back(k + 1 == kept);
				end
				kept = 0;
				sets_closed++;
			end
		endfunction

		function void check_sorted(value_t v, bit eos);
			value_t want_v;
			bit     want_e;
			results_checked++;
			if (sorted_q.size() == 0) begin
				$error("unexpected result: sorted_value %0d end_of_set %0b", v, eos);
				errors++;
			end else begin
				want_v = sorted_q.pop_front();
				want_e = end_q.pop_front();
				if (v !== want_v) begin
					$error("sorted_value: expected %0d, got %0d", want_v, v);
					errors++;
				end
				if (eos !== want_e) begin
					$error("end_of_set: expected %0b, got %0b", want_e, eos);
					errors++;
				end
			end
		endfunction

		function int pending();
			return sorted_q.size();
		endfunction

	endclass

endpackage

FILE: verif/tb_bubble_sort_engine_core.sv
// Testbench top for bubble_sort_engine_core: drives sets of elements and checks sorted output.
// Depends on bse_pkg and on the scoreboard class in bse_sorted_board_pkg.
module tb_bubble_sort_engine_core;

	timeunit 1ns;
	timeprecision 1ps;

	import bse_pkg::*;
	import bse_sorted_board_pkg::*;

	// Kept elements to send over the whole run, and the cycle limit for the whole run.
	localparam int KEPT_TARGET = 310;
	localparam int CYCLE_LIMIT = 200000;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	value_t value = '0;
	logic   is_last = 1'b0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	value_t sorted_value;
	logic   end_of_set;

	sorted_order_board board = new();

	// Elements of the set that is about to be sent, first element first.
	value_t set_q[$];
	// When set, the sender offers items back to back for the whole set.
	bit     back_to_back = 1'b0;
	int     kept_sent = 0;
	int     dropped_sent = 0;
	int     cycle_count = 0;

	bubble_sort_engine_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.end_of_set   (end_of_set)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A hung handshake or a lost result ends the run here instead of hanging the simulator.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_bubble_sort_engine_core NOT OK");
			$finish;
		end
	end

	// Sends the queued set, one item per element, with is_last on the final one. Every item is
	// preceded by a random idle gap unless the set goes out back to back. The payload is set up
	// at a falling edge and held until a rising edge sees in_stall low; the board is told of
	// the item only once it has been accepted.
	task automatic send_queued_set();
		int gap;
		for (int i = 0; i < set_q.size(); i++) begin
			gap = back_to_back ? 0 : $urandom_range(0, 18);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
			@(negedge clk);
			in_valid = 1'b1;
			value = set_q[i];
			is_last = (i + 1 == set_q.size());
			do
				@(posedge clk);
			while (in_stall);
			board.note_element(set_q[i], i + 1 == set_q.size());
			if (i < SIZE)
				kept_sent++;
			else
				dropped_sent++;
		end
	endtask

	// Picks one element value. Style 0 covers the whole 16-bit range, style 1 a narrow band
	// around zero so that equal values are frequent, style 2 the signed extremes, zero and -1.
	function automatic value_t pick_value(int style);
		value_t v;
		case (style)
			0: v = value_t'($urandom);
			1: v = value_t'($urandom_range(0, 6) - 3);
			default: begin
				case ($urandom_range(0, 3))
					0: v = 16'sh8000;
					1: v = 16'sh7fff;
					2: v = 16'sh0000;
					default: v = 16'shffff;
				endcase
			end
		endcase
		return v;
	endfunction

	// Builds and sends one random set. Most sets are small so that sorting stays short; some
	// fill the store, and a few overrun it so that the extra elements are dropped while their
	// is_last flag still closes the set. Sets may be presorted in either direction, which
	// exercises both the early exit and the longest sort.
	task automatic send_random_set();
		int size_pick;
		int set_size;
		int shape;
		int style;
		int start;
		int step;
		size_pick = $urandom_range(0, 9);
		if (size_pick < 7)
			set_size = $urandom_range(1, 6);
		else if (size_pick < 9)
			set_size = $urandom_range(7, SIZE);
		else
			set_size = $urandom_range(SIZE + 1, SIZE + 4);
		shape = $urandom_range(0, 5);
		style = $urandom_range(0, 2);
		start = int'($urandom_range(0, 65000)) - 32768;
		step = $urandom_range(0, 3);
		back_to_back = ($urandom_range(0, 3) == 0);
		set_q.delete();
		for (int i = 0; i < set_size; i++) begin
			case (shape)
				0: set_q.push_back(value_t'(start + i * step));
				1: set_q.push_back(value_t'(start + (set_size - 1 - i) * step));
				default: set_q.push_back(pick_value(style));
			endcase
		end
		send_queued_set();
	endtask

	// Result side. Before every result it stalls for a random number of cycles, with quiet
	// stretches of no stalling in between. Once in the run it holds off for a long stretch so
	// that the engine backs up and stalls the sender, which keeps offering items meanwhile.
	initial begin : result_side
		int hold;
		int quiet_left;
		int taken;
		quiet_left = 0;
		taken = 0;
		forever begin
			if (quiet_left > 0) begin
				hold = 0;
				quiet_left--;
			end else begin
				hold = $urandom_range(0, 18);
				if ($urandom_range(0, 15) == 0)
					quiet_left = $urandom_range(10, 30);
			end
			if (taken == 40)
				hold = 400;
			repeat (hold) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			board.check_sorted(sorted_value, end_of_set);
			taken++;
		end
	end

	initial begin : stimulus
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// A set of one element must come straight back with end_of_set high.
		set_q.delete();
		set_q.push_back(16'sh7fff);
		send_queued_set();

		// Signed extremes, with the most negative value arriving behind the most positive.
		set_q.delete();
		set_q.push_back(16'sh7fff);
		set_q.push_back(16'sh8000);
		set_q.push_back(16'sh0000);
		set_q.push_back(16'shffff);
		send_queued_set();

		// Equal values around a smaller one; equal elements must not be reordered.
		set_q.delete();
		set_q.push_back(16'sd7);
		set_q.push_back(-16'sd7);
		set_q.push_back(16'sd7);
		send_queued_set();

		// Strictly descending full store plus one element past the limit that carries is_last:
		// the longest sort, and a closing flag on a dropped item.
		set_q.delete();
		for (int i = 0; i <= SIZE; i++)
			set_q.push_back(value_t'((SIZE - i) * 2047 - 16000));
		back_to_back = 1'b1;
		send_queued_set();

		while (kept_sent < KEPT_TARGET)
			send_random_set();

		@(negedge clk);
		in_valid = 1'b0;
		is_last = 1'b0;

		// Wait for every predicted result, then keep running so that any stray result is still seen.
		while (board.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d sets: %0d elements kept and %0d dropped past the store size.",
			board.sets_closed, kept_sent, dropped_sent);
		$display("Checked %0d sorted results in %0d cycles.", board.results_checked,
			cycle_count);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb_bubble_sort_engine_core OK");
		else
			$display("tb_bubble_sort_engine_core NOT OK");
		$finish;
	end

endmodule
